// ===== rtl/core/rcv_pkg.sv =====
// Package for the rectangle corner validator: corner indexes and pair map.
package rcv_pkg;

   localparam int NUM_CORNERS = 4;
   localparam int NUM_PAIRS   = 6;
   localparam int PIPE_DEPTH  = 7;

   typedef logic [1:0] corner_idx_type;

   localparam corner_idx_type CRN0 = 2'd0;
   localparam corner_idx_type CRN1 = 2'd1;
   localparam corner_idx_type CRN2 = 2'd2;
   localparam corner_idx_type CRN3 = 2'd3;

   // pair slots for the six squared distances
   localparam int P01 = 0;
   localparam int P02 = 1;
   localparam int P03 = 2;
   localparam int P12 = 3;
   localparam int P13 = 4;
   localparam int P23 = 5;

   localparam corner_idx_type PAIR_A [NUM_PAIRS] = '{CRN0, CRN0, CRN0, CRN1, CRN1, CRN2};
   localparam corner_idx_type PAIR_B [NUM_PAIRS] = '{CRN1, CRN2, CRN3, CRN2, CRN3, CRN3};

endpackage

// ===== rtl/core/rectangle_corner_validator.sv =====
// Rectangle corner validator top level: seven-stage pipeline.
// One request enters per clock; busy is never raised, so start may be held high
// every cycle. Each request gives exactly one response, strobed on rsp_valid after it
// has passed the seven register stages (magnitude, square, sum, compare, order decode,
// side match, final compare), in request order. The response strobe lasts one cycle
// and cannot be held off. Corner 0 always stays first; the others follow a
// nearest-neighbor chain, ties to the lower input index. is_rectangle checks equal
// side pairs and a squared diagonal.
module rectangle_corner_validator #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_corner0_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner0_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner1_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner1_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner2_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner2_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner3_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner3_y,
   output logic                          rsp_valid,
   output logic                          rsp_is_rectangle,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered0_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered0_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered1_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered1_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered2_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered2_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered3_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ordered3_y
);
   import rcv_pkg::*;

   localparam int MAG_W  = COORD_WIDTH + 1;
   localparam int DIST_W = 2 * COORD_WIDTH + 2;
   localparam int HYP_W  = DIST_W + 1;
   localparam int CARRY  = PIPE_DEPTH - 1;

   function automatic logic signed [COORD_WIDTH-1:0] pick(
      input corner_idx_type idx,
      input logic signed [COORD_WIDTH-1:0] v0,
      input logic signed [COORD_WIDTH-1:0] v1,
      input logic signed [COORD_WIDTH-1:0] v2,
      input logic signed [COORD_WIDTH-1:0] v3
   );
      logic signed [COORD_WIDTH-1:0] r;
      case (idx)
         CRN0:    r = v0;
         CRN1:    r = v1;
         CRN2:    r = v2;
         default: r = v3;
      endcase
      return r;
   endfunction

   logic                          accept;
   logic [PIPE_DEPTH-2:0]         vld_ff;
   logic signed [COORD_WIDTH-1:0] in_x [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] in_y [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] cx_ff [CARRY][NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] cy_ff [CARRY][NUM_CORNERS];

   logic [MAG_W-1:0]  magx_ff [NUM_PAIRS];
   logic [MAG_W-1:0]  magy_ff [NUM_PAIRS];
   logic [DIST_W-1:0] sqx_ff  [NUM_PAIRS];
   logic [DIST_W-1:0] sqy_ff  [NUM_PAIRS];
   logic [DIST_W-1:0] d3_ff   [NUM_PAIRS];
   logic [DIST_W-1:0] d4_ff   [NUM_PAIRS];

   // stage 4 compare flags
   logic lt_02_01_ff, lt_03_01_ff, lt_03_02_ff;
   logic lt_13_12_ff, lt_23_12_ff, lt_23_13_ff;

   // stage 5 order and sides
   corner_idx_type    o1_in, o2_in, o3_in;
   corner_idx_type    o1_ff, o2_ff, o3_ff;
   corner_idx_type    o1_s6_ff, o2_s6_ff, o3_s6_ff;
   logic [DIST_W-1:0] side_in [NUM_CORNERS];
   logic [DIST_W-1:0] side_ff [NUM_CORNERS];
   logic [DIST_W-1:0] diag_in, diag_ff;
   logic              first_23;

   // stage 6 checks
   logic              sides_ok_in, sides_ok_ff;
   logic [HYP_W-1:0]  hyp_in, hyp_ff;
   logic [DIST_W-1:0] dsel_in, dsel_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_rect_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] rsp_y_ff [NUM_CORNERS];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign in_x[0] = req_corner0_x;
   assign in_y[0] = req_corner0_y;
   assign in_x[1] = req_corner1_x;
   assign in_y[1] = req_corner1_y;
   assign in_x[2] = req_corner2_x;
   assign in_y[2] = req_corner2_y;
   assign in_x[3] = req_corner3_x;
   assign in_y[3] = req_corner3_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-3:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      cx_ff[0] <= in_x;
      cy_ff[0] <= in_y;
      for (int s = 1; s < CARRY; s++) begin
         cx_ff[s] <= cx_ff[s-1];
         cy_ff[s] <= cy_ff[s-1];
      end
   end

   // stages 1-3: magnitudes, squares, squared distances
   for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
      logic signed [MAG_W-1:0] dx, dy;
      logic [MAG_W-1:0]        ax, ay;
      assign dx = MAG_W'(in_x[PAIR_A[p]]) - MAG_W'(in_x[PAIR_B[p]]);
      assign dy = MAG_W'(in_y[PAIR_A[p]]) - MAG_W'(in_y[PAIR_B[p]]);
      assign ax = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      assign ay = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

      always_ff @(posedge clock) begin
         magx_ff[p] <= ax;
         magy_ff[p] <= ay;
         sqx_ff[p]  <= DIST_W'(magx_ff[p]) * DIST_W'(magx_ff[p]);
         sqy_ff[p]  <= DIST_W'(magy_ff[p]) * DIST_W'(magy_ff[p]);
         d3_ff[p]   <= sqx_ff[p] + sqy_ff[p];
         d4_ff[p]   <= d3_ff[p];
      end
   end

   // stage 4: all chain compares in parallel
   always_ff @(posedge clock) begin
      lt_02_01_ff <= d3_ff[P02] < d3_ff[P01];
      lt_03_01_ff <= d3_ff[P03] < d3_ff[P01];
      lt_03_02_ff <= d3_ff[P03] < d3_ff[P02];
      lt_13_12_ff <= d3_ff[P13] < d3_ff[P12];
      lt_23_12_ff <= d3_ff[P23] < d3_ff[P12];
      lt_23_13_ff <= d3_ff[P23] < d3_ff[P13];
   end

   // stage 5: chain order, sides and middle diagonal
   always_comb begin
      first_23 = lt_02_01_ff ? lt_03_02_ff : lt_03_01_ff;
      o1_in    = first_23 ? CRN3 : (lt_02_01_ff ? CRN2 : CRN1);
      o2_in    = CRN2;
      o3_in    = CRN3;
      side_in[0] = d4_ff[P01];
      side_in[1] = d4_ff[P12];
      side_in[2] = d4_ff[P23];
      side_in[3] = d4_ff[P03];
      diag_in    = d4_ff[P02];
      case (o1_in)
         CRN1: begin
            if (lt_13_12_ff) begin
               o2_in = CRN3; o3_in = CRN2;
               side_in[1] = d4_ff[P13]; side_in[3] = d4_ff[P02];
               diag_in    = d4_ff[P03];
            end
         end
         CRN2: begin
            side_in[0] = d4_ff[P02];
            if (lt_23_12_ff) begin
               o2_in = CRN3; o3_in = CRN1;
               side_in[1] = d4_ff[P23]; side_in[2] = d4_ff[P13];
               side_in[3] = d4_ff[P01]; diag_in = d4_ff[P03];
            end else begin
               o2_in = CRN1; o3_in = CRN3;
               side_in[1] = d4_ff[P12]; side_in[2] = d4_ff[P13];
               side_in[3] = d4_ff[P03]; diag_in = d4_ff[P01];
            end
         end
         default: begin
            side_in[0] = d4_ff[P03];
            if (lt_23_13_ff) begin
               o2_in = CRN2; o3_in = CRN1;
               side_in[1] = d4_ff[P23]; side_in[2] = d4_ff[P12];
               side_in[3] = d4_ff[P01]; diag_in = d4_ff[P02];
            end else begin
               o2_in = CRN1; o3_in = CRN2;
               side_in[1] = d4_ff[P13]; side_in[2] = d4_ff[P12];
               side_in[3] = d4_ff[P02]; diag_in = d4_ff[P01];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      o1_ff   <= o1_in;
      o2_ff   <= o2_in;
      o3_ff   <= o3_in;
      side_ff <= side_in;
      diag_ff <= diag_in;
   end

   // stage 6: side pairing, hypotenuse sum, diagonal pick
   always_comb begin
      sides_ok_in =
         ((side_ff[0] == side_ff[1]) || (side_ff[0] == side_ff[2]) ||
          (side_ff[0] == side_ff[3])) &&
         ((side_ff[1] == side_ff[0]) || (side_ff[1] == side_ff[2]) ||
          (side_ff[1] == side_ff[3])) &&
         ((side_ff[2] == side_ff[0]) || (side_ff[2] == side_ff[1]) ||
          (side_ff[2] == side_ff[3])) &&
         ((side_ff[3] == side_ff[0]) || (side_ff[3] == side_ff[1]) ||
          (side_ff[3] == side_ff[2]));
      hyp_in = HYP_W'(side_ff[0]) +
               HYP_W'((side_ff[0] == side_ff[1]) ? side_ff[2] : side_ff[1]);
      if ((diag_ff == side_ff[0]) || (diag_ff == side_ff[1]) ||
          (diag_ff == side_ff[2]) || (diag_ff == side_ff[3])) begin
         dsel_in = '0;
      end else begin
         dsel_in = diag_ff;
      end
   end

   always_ff @(posedge clock) begin
      sides_ok_ff <= sides_ok_in;
      hyp_ff      <= hyp_in;
      dsel_ff     <= dsel_in;
      o1_s6_ff    <= o1_ff;
      o2_s6_ff    <= o2_ff;
      o3_s6_ff    <= o3_ff;
   end

   // stage 7: response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-2];
      end
   end

   always_ff @(posedge clock) begin
      rsp_rect_ff <= sides_ok_ff && (hyp_ff == HYP_W'(dsel_ff));
      rsp_x_ff[0] <= cx_ff[CARRY-1][0];
      rsp_y_ff[0] <= cy_ff[CARRY-1][0];
      rsp_x_ff[1] <= pick(o1_s6_ff, cx_ff[CARRY-1][0], cx_ff[CARRY-1][1],
                          cx_ff[CARRY-1][2], cx_ff[CARRY-1][3]);
      rsp_y_ff[1] <= pick(o1_s6_ff, cy_ff[CARRY-1][0], cy_ff[CARRY-1][1],
                          cy_ff[CARRY-1][2], cy_ff[CARRY-1][3]);
      rsp_x_ff[2] <= pick(o2_s6_ff, cx_ff[CARRY-1][0], cx_ff[CARRY-1][1],
                          cx_ff[CARRY-1][2], cx_ff[CARRY-1][3]);
      rsp_y_ff[2] <= pick(o2_s6_ff, cy_ff[CARRY-1][0], cy_ff[CARRY-1][1],
                          cy_ff[CARRY-1][2], cy_ff[CARRY-1][3]);
      rsp_x_ff[3] <= pick(o3_s6_ff, cx_ff[CARRY-1][0], cx_ff[CARRY-1][1],
                          cx_ff[CARRY-1][2], cx_ff[CARRY-1][3]);
      rsp_y_ff[3] <= pick(o3_s6_ff, cy_ff[CARRY-1][0], cy_ff[CARRY-1][1],
                          cy_ff[CARRY-1][2], cy_ff[CARRY-1][3]);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_rectangle = rsp_rect_ff;
   assign rsp_ordered0_x   = rsp_x_ff[0];
   assign rsp_ordered0_y   = rsp_y_ff[0];
   assign rsp_ordered1_x   = rsp_x_ff[1];
   assign rsp_ordered1_y   = rsp_y_ff[1];
   assign rsp_ordered2_x   = rsp_x_ff[2];
   assign rsp_ordered2_y   = rsp_y_ff[2];
   assign rsp_ordered3_x   = rsp_x_ff[3];
   assign rsp_ordered3_y   = rsp_y_ff[3];

`ifndef SYNTH
   // a response only comes from a request that was accepted and has run the whole pipeline
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("response without matching request");

   // chain order is a permutation of corners 1..3
   a_order_perm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (o1_ff != CRN0) && (o2_ff != CRN0) && (o3_ff != CRN0) &&
                    (o1_ff != o2_ff) && (o1_ff != o3_ff) && (o2_ff != o3_ff))
      else $error("corner order is not a permutation");

   // corner 0 leads the chain unchanged
   a_first_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ordered0_x == $past(req_corner0_x, PIPE_DEPTH)) &&
                    (rsp_ordered0_y == $past(req_corner0_y, PIPE_DEPTH)))
      else $error("first ordered corner differs from corner 0");
`endif

endmodule

// ===== dv/rect_result_check.sv =====
// Checker for the rectangle corner validator: predicts each response and compares it.
module rect_result_check #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_corner0_x,
   input  logic [COORD_WIDTH-1:0] req_corner0_y,
   input  logic [COORD_WIDTH-1:0] req_corner1_x,
   input  logic [COORD_WIDTH-1:0] req_corner1_y,
   input  logic [COORD_WIDTH-1:0] req_corner2_x,
   input  logic [COORD_WIDTH-1:0] req_corner2_y,
   input  logic [COORD_WIDTH-1:0] req_corner3_x,
   input  logic [COORD_WIDTH-1:0] req_corner3_y,
   input  logic                   rsp_valid,
   input  logic                   rsp_is_rectangle,
   input  logic [COORD_WIDTH-1:0] rsp_ordered0_x,
   input  logic [COORD_WIDTH-1:0] rsp_ordered0_y,
   input  logic [COORD_WIDTH-1:0] rsp_ordered1_x,
   input  logic [COORD_WIDTH-1:0] rsp_ordered1_y,
   input  logic [COORD_WIDTH-1:0] rsp_ordered2_x,
   input  logic [COORD_WIDTH-1:0] rsp_ordered2_y,
   input  logic [COORD_WIDTH-1:0] rsp_ordered3_x,
   input  logic [COORD_WIDTH-1:0] rsp_ordered3_y,
   output int                     fail_count,
   output int                     backlog
);

   timeunit 1ns;
   timeprecision 1ps;

   import rcv_pkg::*;

   localparam int MAX_PRINTED = 100;
   localparam int DUE_DEPTH   = 16;

   typedef logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] corner_set_type;

   typedef struct packed {
      logic           is_rect;
      corner_set_type ox;
      corner_set_type oy;
   } rect_answer_type;

   corner_set_type  req_xs, req_ys, rsp_xs, rsp_ys;
   rect_answer_type answers_due [DUE_DEPTH];
   rect_answer_type due;
   int              due_wr = 0;
   int              due_rd = 0;

   assign req_xs = {req_corner3_x, req_corner2_x, req_corner1_x, req_corner0_x};
   assign req_ys = {req_corner3_y, req_corner2_y, req_corner1_y, req_corner0_y};
   assign rsp_xs = {rsp_ordered3_x, rsp_ordered2_x, rsp_ordered1_x, rsp_ordered0_x};
   assign rsp_ys = {rsp_ordered3_y, rsp_ordered2_y, rsp_ordered1_y, rsp_ordered0_y};

   function automatic longint span_sq(corner_set_type xs, corner_set_type ys, int a, int b);
      longint dx, dy;
      dx = longint'($signed(xs[a])) - longint'($signed(xs[b]));
      dy = longint'($signed(ys[a])) - longint'($signed(ys[b]));
      return dx * dx + dy * dy;
   endfunction

   function automatic rect_answer_type predict_rectangle(corner_set_type xs,
                                                         corner_set_type ys);
      rect_answer_type ans;
      int              chain [NUM_CORNERS];
      bit              taken [NUM_CORNERS];
      corner_set_type  ox, oy;
      longint          side [NUM_CORNERS];
      longint          best_d, d, hyp, diag;
      int              best;
      bit              ok, hit;
      for (int i = 0; i < NUM_CORNERS; i++)
         taken[i] = 1'b0;
      chain[0] = 0;
      taken[0] = 1'b1;
      // nearest-neighbor chain, ties keep the lower index
      for (int i = 1; i < NUM_CORNERS; i++) begin
         best = -1;
         best_d = 0;
         for (int j = 1; j < NUM_CORNERS; j++) begin
            if (!taken[j]) begin
               d = span_sq(xs, ys, chain[i-1], j);
               if (best < 0 || d < best_d) begin
                  best = j;
                  best_d = d;
               end
            end
         end
         if (best < 0)
            best = 0;
         chain[i] = best;
         taken[best] = 1'b1;
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
         ox[i] = xs[chain[i]];
         oy[i] = ys[chain[i]];
      end
      for (int i = 0; i < NUM_CORNERS; i++)
         side[i] = span_sq(ox, oy, i, (i + 1) % NUM_CORNERS);
      ok = 1'b1;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         hit = 1'b0;
         for (int j = 0; j < NUM_CORNERS; j++)
            if (i != j && side[i] == side[j])
               hit = 1'b1;
         if (!hit)
            ok = 1'b0;
      end
      if (ok) begin
         hyp = side[0] + ((side[0] == side[1]) ? side[2] : side[1]);
         diag = 0;
         for (int i = 1; i < NUM_CORNERS && diag == 0; i++) begin
            d = span_sq(ox, oy, 0, i);
            hit = 1'b0;
            for (int j = 0; j < NUM_CORNERS; j++)
               if (d == side[j])
                  hit = 1'b1;
            if (!hit)
               diag = d;
         end
         if (hyp != diag)
            ok = 1'b0;
      end
      ans.is_rect = ok;
      ans.ox = ox;
      ans.oy = oy;
      return ans;
   endfunction

   task automatic report_mismatch(string note);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("%t mismatch: %s", $time, note);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_wr == due_rd) begin
            report_mismatch("response with no request outstanding");
         end else begin
            due = answers_due[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_is_rectangle !== due.is_rect)
               report_mismatch($sformatf("is_rectangle: expected %0d, got %0b",
                                         due.is_rect, rsp_is_rectangle));
            for (int i = 0; i < NUM_CORNERS; i++) begin
               if (rsp_xs[i] !== due.ox[i])
                  report_mismatch($sformatf("ordered%0d_x: expected %0d, got %0d",
                                            i, $signed(due.ox[i]), $signed(rsp_xs[i])));
               if (rsp_ys[i] !== due.oy[i])
                  report_mismatch($sformatf("ordered%0d_y: expected %0d, got %0d",
                                            i, $signed(due.oy[i]), $signed(rsp_ys[i])));
            end
         end
      end
      if (!reset && start && !busy) begin
         if (due_wr - due_rd >= DUE_DEPTH) begin
            report_mismatch("too many requests outstanding");
         end else begin
            answers_due[due_wr % DUE_DEPTH] = predict_rectangle(req_xs, req_ys);
            due_wr++;
         end
      end
      backlog = due_wr - due_rd;
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the rectangle corner validator: clock, reset, requests and verdict.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import rcv_pkg::*;

   localparam int CW          = 16;
   localparam int RANDOM_REQS = 750;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_DIRECTED = 22;

   typedef logic [NUM_CORNERS-1:0][CW-1:0] corner_set_type;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   corner_set_type req_x, req_y;
   logic           rsp_valid;
   logic           rsp_is_rectangle;
   logic [CW-1:0] rsp_ordered0_x, rsp_ordered0_y, rsp_ordered1_x, rsp_ordered1_y;
   logic [CW-1:0] rsp_ordered2_x, rsp_ordered2_y, rsp_ordered3_x, rsp_ordered3_y;
   int          fail_count;
   int          backlog;
   int          cycle_count = 0;

   // x0, y0, x1, y1, x2, y2, x3, y3
   int directed_sets [NUM_DIRECTED][8] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767},
      '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
      '{0, 0, 4, 0, 4, 3, 0, 3},
      '{0, 0, 4, 3, 0, 3, 4, 0},
      '{0, 0, -5, 10, -8, 6, 3, 4},
      '{0, 0, 2, 0, 0, 2, 2, 2},
      '{2, 2, 0, 0, 0, 2, 2, 0},
      '{0, 0, 2, 1, 4, 0, 2, -1},
      '{0, 0, 4, 0, 5, 2, 1, 2},
      '{0, 0, 1, 2, 0, 5, -1, 2},
      '{0, 0, 1, 0, 2, 0, 3, 0},
      '{0, 0, 0, 0, 5, 5, 5, 5},
      '{0, 0, 1, 0, 0, 0, 1, 0},
      '{7, 7, 7, 7, 7, 7, -7, 7},
      '{0, 0, 6, 0, 4, 3, 2, 3},
      '{-32768, -32768, -32768, 0, -1, 0, -1, -32768},
      '{0, 0, 100, 0, 100, 50, 1, 50},
      '{0, 0, 20000, 10000, 10000, 30000, -10000, 20000},
      '{-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845}
   };

   rectangle_corner_validator #(
      .COORD_WIDTH(CW)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_corner0_x    (req_x[0]),
      .req_corner0_y    (req_y[0]),
      .req_corner1_x    (req_x[1]),
      .req_corner1_y    (req_y[1]),
      .req_corner2_x    (req_x[2]),
      .req_corner2_y    (req_y[2]),
      .req_corner3_x    (req_x[3]),
      .req_corner3_y    (req_y[3]),
      .rsp_valid        (rsp_valid),
      .rsp_is_rectangle (rsp_is_rectangle),
      .rsp_ordered0_x   (rsp_ordered0_x),
      .rsp_ordered0_y   (rsp_ordered0_y),
      .rsp_ordered1_x   (rsp_ordered1_x),
      .rsp_ordered1_y   (rsp_ordered1_y),
      .rsp_ordered2_x   (rsp_ordered2_x),
      .rsp_ordered2_y   (rsp_ordered2_y),
      .rsp_ordered3_x   (rsp_ordered3_x),
      .rsp_ordered3_y   (rsp_ordered3_y)
   );

   rect_result_check #(
      .COORD_WIDTH(CW)
   ) result_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_corner0_x    (req_x[0]),
      .req_corner0_y    (req_y[0]),
      .req_corner1_x    (req_x[1]),
      .req_corner1_y    (req_y[1]),
      .req_corner2_x    (req_x[2]),
      .req_corner2_y    (req_y[2]),
      .req_corner3_x    (req_x[3]),
      .req_corner3_y    (req_y[3]),
      .rsp_valid        (rsp_valid),
      .rsp_is_rectangle (rsp_is_rectangle),
      .rsp_ordered0_x   (rsp_ordered0_x),
      .rsp_ordered0_y   (rsp_ordered0_y),
      .rsp_ordered1_x   (rsp_ordered1_x),
      .rsp_ordered1_y   (rsp_ordered1_y),
      .rsp_ordered2_x   (rsp_ordered2_x),
      .rsp_ordered2_y   (rsp_ordered2_y),
      .rsp_ordered3_x   (rsp_ordered3_x),
      .rsp_ordered3_y   (rsp_ordered3_y),
      .fail_count       (fail_count),
      .backlog          (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int spick(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // integer rectangle from a corner, a side vector and a scaled perpendicular, then shuffled
   function automatic void build_rectangle(output corner_set_type xs,
                                           output corner_set_type ys,
                                           input int reach, input int scale);
      int px, py, a, b, k, j;
      int cx [NUM_CORNERS];
      int cy [NUM_CORNERS];
      logic [CW-1:0] t;
      px = spick(16000);
      py = spick(16000);
      a = spick(reach);
      b = spick(reach);
      k = spick(scale);
      if (k == 0)
         k = 1;
      cx[0] = px;             cy[0] = py;
      cx[1] = px + a;         cy[1] = py + b;
      cx[2] = px + a - b * k; cy[2] = py + b + a * k;
      cx[3] = px - b * k;     cy[3] = py + a * k;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         xs[i] = cx[i][CW-1:0];
         ys[i] = cy[i][CW-1:0];
      end
      for (int i = NUM_CORNERS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = xs[i]; xs[i] = xs[j]; xs[j] = t;
         t = ys[i]; ys[i] = ys[j]; ys[j] = t;
      end
   endfunction

   task automatic send_request(corner_set_type xs, corner_set_type ys);
      @(negedge clock);
      start <= 1'b1;
      req_x <= xs;
      req_y <= ys;
      while (busy)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic idle_for(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         req_x <= {$urandom, $urandom};
         req_y <= {$urandom, $urandom};
      end
   endtask

   initial begin
      corner_set_type xs, ys;
      corner_set_type px, py;
      int sel, idx, quiet_run;
      reset = 1'b1;
      start = 1'b0;
      req_x = '0;
      req_y = '0;
      quiet_run = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < NUM_DIRECTED; n++) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            xs[i] = directed_sets[n][2*i][CW-1:0];
            ys[i] = directed_sets[n][2*i+1][CW-1:0];
         end
         send_request(xs, ys);
         idle_for(n % 3);
      end

      for (int n = 0; n < RANDOM_REQS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            build_rectangle(xs, ys, 90, 40);
         end else if (sel < 55) begin
            build_rectangle(xs, ys, 16000, 1);
         end else if (sel < 65) begin
            build_rectangle(xs, ys, 6, 3);
         end else if (sel < 75) begin
            build_rectangle(xs, ys, 60, 20);
            idx = $urandom_range(0, NUM_CORNERS - 1);
            if ($urandom_range(0, 1))
               xs[idx] = xs[idx] + CW'(spick(2));
            else
               ys[idx] = ys[idx] + CW'(spick(2));
         end else if (sel < 88) begin
            xs = {$urandom, $urandom};
            ys = {$urandom, $urandom};
         end else if (sel < 95) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
               xs[i] = CW'(spick(3));
               ys[i] = CW'(spick(3));
            end
         end else begin
            px = {$urandom, $urandom};
            py = {$urandom, $urandom};
            for (int i = 0; i < NUM_CORNERS; i++) begin
               idx = $urandom_range(0, 1);
               xs[i] = px[idx];
               ys[i] = py[idx];
            end
         end
         send_request(xs, ys);

         if (n == RANDOM_REQS / 2 || $urandom_range(0, 199) == 0) begin
            idle_for(1);
            while (backlog != 0)
               @(negedge clock);
         end else if (quiet_run > 0) begin
            quiet_run--;
         end else if ($urandom_range(0, 49) == 0) begin
            quiet_run = $urandom_range(20, 60);
         end else begin
            idle_for(pick_gap());
         end
      end

      idle_for(1);
      while (backlog != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
